>>> hw/rtl/cbor_rd_pkg.sv
// Package for the CBOR item reader: field widths, status codes, phase and
// kind encodings, and head-byte constants. No dependencies.
package cbor_rd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 2;
  localparam int unsigned LenW    = 16;
  localparam int unsigned CapW    = 17;
  localparam int unsigned StatusW = 3;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned ArgCntW = 4;

  typedef enum logic [StatusW-1:0] {
    StOk       = 3'd0,
    StType     = 3'd1,
    StUnderrun = 3'd2,
    StInvalid  = 3'd3,
    StOverflow = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhArg     = 2'd1,
    PhPayload = 2'd2
  } phase_e;

  localparam logic [KindW-1:0] KindUint  = 2'd0;
  localparam logic [KindW-1:0] KindBytes = 2'd1;
  localparam logic [KindW-1:0] KindText  = 2'd2;

  localparam logic [2:0] MajUint  = 3'd0;
  localparam logic [2:0] MajBytes = 3'd2;
  localparam logic [2:0] MajText  = 3'd3;

  localparam logic [4:0] InfoImmLimit = 5'd24;
  localparam logic [4:0] InfoArg1     = 5'd24;
  localparam logic [4:0] InfoArg2     = 5'd25;
  localparam logic [4:0] InfoArg4     = 5'd26;
  localparam logic [4:0] InfoArg8     = 5'd27;

endpackage

>>> hw/rtl/cbor_rd_in_if.sv
// Input channel of the CBOR item reader: one buffer word with its framing
// and the per-item expectations. Depends on cbor_rd_pkg.
interface cbor_rd_in_if
  import cbor_rd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             item_start;
  logic             buffer_last;
  logic [KindW-1:0] expected_kind;
  logic [LenW-1:0]  expected_length;
  logic [CapW-1:0]  text_capacity;

  modport source (
    output valid, data_byte, item_start, buffer_last, expected_kind,
           expected_length, text_capacity,
    input  ready
  );
  modport sink (
    input  valid, data_byte, item_start, buffer_last, expected_kind,
           expected_length, text_capacity,
    output ready
  );
endinterface

>>> hw/rtl/cbor_rd_out_if.sv
// Result channel of the CBOR item reader: status, value and payload word.
// Depends on cbor_rd_pkg.
interface cbor_rd_out_if
  import cbor_rd_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [ValueW-1:0]  decoded_value;
  logic [ByteW-1:0]   payload_byte;
  logic               payload_valid;
  logic               item_done;

  modport source (
    output valid, status, decoded_value, payload_byte, payload_valid, item_done,
    input  ready
  );
  modport sink (
    input  valid, status, decoded_value, payload_byte, payload_valid, item_done,
    output ready
  );
endinterface

>>> hw/rtl/cbor_item_reader_core.sv
// CBOR item reader top level: per-word decode and result register.
// Depends on cbor_rd_pkg, cbor_rd_in_if and cbor_rd_out_if.
//
// Usage:
//   in_i carries the encoded buffer one word per beat. item_start marks the
//   head word of an item; the expected kind, byte string length and text
//   capacity are sampled on that word. buffer_last marks the final word.
//   out_o gives at most one result word per input word: payload words of a
//   string as they arrive, and a final word with item_done set that carries
//   the status and, on success, the integer value or string length.
//   A result appears on out_o in the cycle after its input word is taken.
//   Throughput: one input word per cycle while in_i.ready is high.
//   Stall: in_i.ready is high while the result register is empty or being
//   emptied this cycle; a held result blocks only the next input word.
//   Reset: phase returns to idle, the result register empties, and the
//   latched kind, counters and accumulator clear.
//   A head word in the middle of an item drops the old item without result.
module cbor_item_reader_core
  import cbor_rd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  cbor_rd_in_if.sink    in_i,
  cbor_rd_out_if.source out_o
);

  phase_e               phase_q, phase_d;
  logic [KindW-1:0]     kind_q, kind_d;
  logic [ArgCntW-1:0]   arg_left_q, arg_left_d;
  logic [ValueW-1:0]    acc_q, acc_d;
  logic [LenW-1:0]      pl_left_q, pl_left_d;
  logic [LenW-1:0]      len_exp_q, len_exp_d;
  logic [CapW-1:0]      cap_q, cap_d;

  logic                 out_valid_q, out_valid_d;
  status_e              status_q, status_d;
  logic [ValueW-1:0]    value_q, value_d;
  logic [ByteW-1:0]     pbyte_q, pbyte_d;
  logic                 pvalid_q, pvalid_d;
  logic                 done_q, done_d;

  logic                 accept;
  logic                 res_valid;
  logic                 do_complete;
  logic [KindW-1:0]     ck_kind;
  logic [LenW-1:0]      ck_len_exp;
  logic [CapW-1:0]      ck_cap;
  logic [2:0]           major;
  logic [4:0]           info;
  logic [2:0]           want;
  logic [LenW-1:0]      len;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign major      = in_i.data_byte[7:5];
  assign info       = in_i.data_byte[4:0];

  always_comb begin
    phase_d     = phase_q;
    kind_d      = kind_q;
    arg_left_d  = arg_left_q;
    acc_d       = acc_q;
    pl_left_d   = pl_left_q;
    len_exp_d   = len_exp_q;
    cap_d       = cap_q;
    res_valid   = 1'b0;
    status_d    = StOk;
    value_d     = '0;
    pbyte_d     = '0;
    pvalid_d    = 1'b0;
    done_d      = 1'b0;
    do_complete = 1'b0;
    ck_kind     = kind_q;
    ck_len_exp  = len_exp_q;
    ck_cap      = cap_q;
    want        = MajUint;

    if (in_i.item_start) begin
      kind_d     = in_i.expected_kind;
      len_exp_d  = in_i.expected_length;
      cap_d      = in_i.text_capacity;
      arg_left_d = '0;
      pl_left_d  = '0;
      phase_d    = PhIdle;
      ck_kind    = in_i.expected_kind;
      ck_len_exp = in_i.expected_length;
      ck_cap     = in_i.text_capacity;
      unique case (in_i.expected_kind)
        KindUint:  want = MajUint;
        KindBytes: want = MajBytes;
        KindText:  want = MajText;
        default:   want = MajUint;
      endcase
      if (in_i.expected_kind == KindText && in_i.text_capacity == '0) begin
        res_valid = 1'b1;
        status_d  = StInvalid;
      end else if (in_i.expected_kind != KindUint && in_i.expected_kind != KindBytes &&
                   in_i.expected_kind != KindText) begin
        res_valid = 1'b1;
        status_d  = StType;
      end else if (major != want) begin
        res_valid = 1'b1;
        status_d  = StType;
      end else if (info < InfoImmLimit) begin
        acc_d       = {{(ValueW-5){1'b0}}, info};
        do_complete = 1'b1;
      end else begin
        acc_d = '0;
        unique case (info)
          InfoArg1: arg_left_d = 4'd1;
          InfoArg2: arg_left_d = 4'd2;
          InfoArg4: arg_left_d = (in_i.expected_kind == KindUint) ? 4'd4 : 4'd0;
          InfoArg8: arg_left_d = (in_i.expected_kind == KindUint) ? 4'd8 : 4'd0;
          default:  arg_left_d = 4'd0;
        endcase
        if (arg_left_d == '0) begin
          res_valid = 1'b1;
          status_d  = StInvalid;
        end else if (in_i.buffer_last) begin
          res_valid = 1'b1;
          status_d  = StUnderrun;
        end else begin
          phase_d = PhArg;
        end
      end
    end else if (phase_q == PhArg) begin
      acc_d      = {acc_q[ValueW-ByteW-1:0], in_i.data_byte};
      arg_left_d = arg_left_q - 4'd1;
      if (arg_left_d == '0) begin
        do_complete = 1'b1;
      end else if (in_i.buffer_last) begin
        res_valid = 1'b1;
        status_d  = StUnderrun;
      end
    end else if (phase_q == PhPayload) begin
      pl_left_d = pl_left_q - 16'd1;
      res_valid = 1'b1;
      pbyte_d   = in_i.data_byte;
      pvalid_d  = 1'b1;
      if (pl_left_d == '0) begin
        status_d = StOk;
        value_d  = {{(ValueW-LenW){1'b0}}, acc_q[LenW-1:0]};
        done_d   = 1'b1;
      end else if (in_i.buffer_last) begin
        status_d = StUnderrun;
        done_d   = 1'b1;
      end
    end

    len = acc_d[LenW-1:0];
    if (do_complete) begin
      if (ck_kind == KindUint) begin
        res_valid = 1'b1;
        status_d  = StOk;
        value_d   = acc_d;
      end else if (ck_kind == KindBytes && len != ck_len_exp) begin
        res_valid = 1'b1;
        status_d  = StInvalid;
      end else if (ck_kind == KindText && {1'b0, len} >= ck_cap) begin
        res_valid = 1'b1;
        status_d  = StOverflow;
      end else if (len == '0) begin
        res_valid = 1'b1;
        status_d  = StOk;
      end else if (in_i.buffer_last) begin
        res_valid = 1'b1;
        status_d  = StUnderrun;
      end else begin
        phase_d   = PhPayload;
        pl_left_d = len;
      end
    end

    // every result outside the payload stream closes the item
    if (res_valid && !pvalid_d) begin
      done_d = 1'b1;
    end
    if (res_valid && done_d) begin
      phase_d = PhIdle;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = res_valid;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      kind_q      <= '0;
      arg_left_q  <= '0;
      acc_q       <= '0;
      pl_left_q   <= '0;
      len_exp_q   <= '0;
      cap_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        phase_q    <= phase_d;
        kind_q     <= kind_d;
        arg_left_q <= arg_left_d;
        acc_q      <= acc_d;
        pl_left_q  <= pl_left_d;
        len_exp_q  <= len_exp_d;
        cap_q      <= cap_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      status_q <= status_d;
      value_q  <= value_d;
      pbyte_q  <= pbyte_d;
      pvalid_q <= pvalid_d;
      done_q   <= done_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = status_q;
  assign out_o.decoded_value = value_q;
  assign out_o.payload_byte  = pbyte_q;
  assign out_o.payload_valid = pvalid_q;
  assign out_o.item_done     = done_q;

  a_arg_count_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhArg |-> arg_left_q != '0)
    else $error("argument phase with no bytes left");

  a_payload_count_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPayload |-> pl_left_q != '0)
    else $error("payload phase with no bytes left");

  a_payload_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && pvalid_q |-> (status_q == StOk || status_q == StUnderrun))
    else $error("payload word with error status");

  a_value_on_success : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && value_q != '0 |-> status_q == StOk && done_q)
    else $error("value reported outside a successful final word");

  a_accept_idle_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res_valid |=> out_valid_q)
    else $error("result lost at the output register");

endmodule
